[rtl/core/lrut_pkg.sv]
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared types, constants and helpers for the LRU set recency tracker.
// ----------------------------------------------------------------------------
package lrut_pkg;

   localparam int NUM_SETS  = 256;
   localparam int WAYS      = 8;
   localparam int SET_W     = $clog2(NUM_SETS);
   localparam int WAY_W     = $clog2(WAYS);

   // request and response field widths
   localparam int ACT_W     = 2;
   localparam int SET_IN_W  = 8;
   localparam int WAY_IN_W  = 3;
   localparam int VICTIM_W  = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // csr
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ALLOC_W     = 4;
   localparam logic [ALLOC_W-1:0] ALLOC_RESET = 4'd8;
   localparam logic [0:0] CSR_IDX_ALLOC_WAYS = 1'b0;

   // decoupling queue
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   typedef enum logic [ACT_W-1:0] {
      ACT_TOUCH      = 2'd0,
      ACT_INSERT     = 2'd1,
      ACT_INVALIDATE = 2'd2,
      ACT_QUERY      = 2'd3
   } action_type;

   // one recency row, entry 0 is the most recently used way
   typedef logic [WAYS-1:0][WAY_W-1:0] row_type;
   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      action_type       action;
      logic [SET_W-1:0] set;
      logic [WAY_W-1:0] way;
      logic             way_ok;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // order after reset: ways in index order, head to tail
   function automatic row_type row_reset();
      row_type r;
      for (int p = 0; p < WAYS; p++) begin
         r[p] = WAY_W'(p);
      end
      return r;
   endfunction

endpackage

[rtl/core/lru_set_recency_tracker_core.sv]
// ----------------------------------------------------------------------------
// lru_set_recency_tracker_core
// Per-set LRU order keeper with victim selection for a set-associative cache.
// ----------------------------------------------------------------------------
// Each request word (action in tuser, set and way in tdata) gives exactly one
// response word. Touch and insert move the way to the head of its set,
// invalidate moves it to the tail, a query returns the way nearest the tail
// that lies below alloc_ways (csr offset 0x0) with a found flag. Requests go
// through a two-word queue into a read/update pipeline on the 256-row
// recency RAM: one row read per cycle and one write per cycle, with the
// just-written row forwarded to a following request on the same set, so the
// sustained rate is one word per cycle while rsp_tready is high. A request
// passes the queue, the read stage and the response register. Rows never
// written read as ways in index order; a per-row valid bit cleared by
// reset gives this, so there is no clearing pass after reset.
module lru_set_recency_tracker_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrut_pkg::REQ_DATA_W-1:0]     req_tdata,  // set_index[7:0], way[10:8]
   input  logic [lrut_pkg::ACT_W-1:0]          req_tuser,  // action[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lrut_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // victim_way[2:0]
   output logic [0:0]                          rsp_tuser,  // victim_found[0]
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lrut_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lrut_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lrut_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [lrut_pkg::ALLOC_W-1:0]  alloc_ways_ff, alloc_ways_in;
   logic [0:0]                    csr_idx;
   logic                          csr_wr;

   lrut_pkg::q_stat_type          q_stat;
   lrut_pkg::item_type            push_item, pop_item;
   logic                          push, pop;
   logic [lrut_pkg::VICTIM_W-1:0] victim_way;
   logic                          victim_found;

   // register index is the word address
   assign csr_idx       = csr_paddr[lrut_pkg::CSR_ADDR_W-1 -: 1];
   assign csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready    = 1'b1;
   assign alloc_ways_in = (csr_wr && csr_idx == lrut_pkg::CSR_IDX_ALLOC_WAYS)
                          ? csr_pwdata[lrut_pkg::ALLOC_W-1:0] : alloc_ways_ff;
   assign csr_prdata    = (csr_idx == lrut_pkg::CSR_IDX_ALLOC_WAYS)
                          ? lrut_pkg::CSR_DATA_W'(alloc_ways_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ways_ff <= lrut_pkg::ALLOC_RESET;
      end else begin
         alloc_ways_ff <= alloc_ways_in;
      end
   end

   lrut_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   lrut_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   lrut_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .q_item           (pop_item),
      .pop              (pop),
      .alloc_ways       (alloc_ways_ff),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_victim_way   (victim_way),
      .rsp_victim_found (victim_found)
   );

   assign rsp_tdata = lrut_pkg::RSP_DATA_W'(victim_way);
   assign rsp_tuser = victim_found;

endmodule

[rtl/core/lrut_ram.sv]
// ----------------------------------------------------------------------------
// lrut_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrut_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lrut_front.sv]
// ----------------------------------------------------------------------------
// lrut_front
// Takes request words, decodes action, set and way, and pushes them to the
// queue in front of the row update logic.
// ----------------------------------------------------------------------------
module lrut_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrut_pkg::REQ_DATA_W-1:0]     req_tdata,  // set_index[7:0], way[10:8]
   input  logic [lrut_pkg::ACT_W-1:0]          req_tuser,  // action[1:0]
   input  lrut_pkg::q_stat_type                q_stat,
   output logic                                push,
   output lrut_pkg::item_type                  push_item
);

   logic [31:0] way32;
   logic [31:0] set32;

   always_comb begin
      way32 = 32'(req_tdata[lrut_pkg::SET_IN_W +: lrut_pkg::WAY_IN_W]);
      set32 = 32'(req_tdata[lrut_pkg::SET_IN_W-1:0]);

      push_item.action = lrut_pkg::action_type'(req_tuser);
      // set count is a power of two: modulo is the low bits
      push_item.set    = set32[lrut_pkg::SET_W-1:0];
      push_item.way    = way32[lrut_pkg::WAY_W-1:0];
      push_item.way_ok = (way32 < 32'(lrut_pkg::WAYS));
   end

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && !q_stat.full;

endmodule

[rtl/core/lrut_queue.sv]
// ----------------------------------------------------------------------------
// lrut_queue
// Short FIFO of decoded requests between front and back.
// ----------------------------------------------------------------------------
module lrut_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lrut_pkg::item_type     push_item,
   input  logic                   pop,
   output lrut_pkg::item_type     pop_item,
   output lrut_pkg::q_stat_type   q_stat
);

   lrut_pkg::item_type                entry_ff [lrut_pkg::Q_DEPTH];
   logic [lrut_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lrut_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lrut_pkg::Q_CNT_W-1:0]      cnt_ff, cnt_in;

   function automatic logic [lrut_pkg::Q_PTR_W-1:0] ptr_next(
      input logic [lrut_pkg::Q_PTR_W-1:0] p
   );
      logic [lrut_pkg::Q_PTR_W-1:0] n;
      if (32'(p) == lrut_pkg::Q_DEPTH - 1) n = '0;
      else n = p + 1'b1;
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (32'(cnt_ff) == lrut_pkg::Q_DEPTH);
   assign q_stat.empty = (cnt_ff == '0);

endmodule

[rtl/core/lrut_back.sv]
// ----------------------------------------------------------------------------
// lrut_back
// Reads a set's recency row, applies touch, insert, invalidate or victim
// query, writes the row back and registers the response word.
// ----------------------------------------------------------------------------
module lrut_back (
   input  logic                             clock,
   input  logic                             reset,
   input  lrut_pkg::q_stat_type             q_stat,
   input  lrut_pkg::item_type               q_item,
   output logic                             pop,
   input  logic [lrut_pkg::ALLOC_W-1:0]     alloc_ways,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lrut_pkg::VICTIM_W-1:0]    rsp_victim_way,
   output logic                             rsp_victim_found
);

   // read stage result waiting for the update stage
   logic                          b_vld_ff, b_vld_in;
   lrut_pkg::item_type            b_item_ff;
   logic                          b_fwd_ff;
   logic                          b_rowvld_ff;
   lrut_pkg::row_type             wb_row_ff;
   logic [lrut_pkg::NUM_SETS-1:0] row_vld_ff;

   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [lrut_pkg::VICTIM_W-1:0] rsp_way_ff;
   logic                          rsp_found_ff;

   logic                          out_free, b_go, issue, fwd;
   logic [lrut_pkg::ROW_W-1:0]    ram_rd_data;
   lrut_pkg::row_type             cur_row, new_row;
   logic [lrut_pkg::WAY_W-1:0]    pos;
   logic                          pos_found;
   logic [lrut_pkg::VICTIM_W-1:0] victim;
   logic                          found;
   logic [31:0]                   tail_way32;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign b_go     = b_vld_ff && out_free;
   assign issue    = !q_stat.empty && (!b_vld_ff || b_go);
   assign pop      = issue;
   // same set as the row being written now: take the fresh row, not the RAM
   assign fwd      = b_go && (q_item.set == b_item_ff.set);
   assign b_vld_in = issue ? 1'b1 : (b_go ? 1'b0 : b_vld_ff);

   lrut_ram #(
      .WIDTH (lrut_pkg::ROW_W),
      .DEPTH (lrut_pkg::NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (b_go),
      .wr_addr (b_item_ff.set),
      .wr_data (new_row),
      .rd_en   (issue),
      .rd_addr (q_item.set),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (b_fwd_ff) cur_row = wb_row_ff;
      else if (b_rowvld_ff) cur_row = lrut_pkg::row_type'(ram_rd_data);
      else cur_row = lrut_pkg::row_reset();

      pos       = '0;
      pos_found = 1'b0;
      for (int p = lrut_pkg::WAYS - 1; p >= 0; p--) begin
         if (cur_row[p] == b_item_ff.way) begin
            pos       = lrut_pkg::WAY_W'(p);
            pos_found = 1'b1;
         end
      end

      // scan ends at the entry nearest the tail
      victim     = '0;
      found      = 1'b0;
      tail_way32 = '0;
      for (int i = 0; i < lrut_pkg::WAYS; i++) begin
         if (32'(cur_row[i]) < 32'(alloc_ways)) begin
            tail_way32 = 32'(cur_row[i]);
            found      = 1'b1;
         end
      end

      new_row = cur_row;
      case (b_item_ff.action)
         lrut_pkg::ACT_TOUCH, lrut_pkg::ACT_INSERT: begin
            if (b_item_ff.way_ok && pos_found) begin
               for (int p = 0; p < lrut_pkg::WAYS; p++) begin
                  if (p == 0) new_row[p] = b_item_ff.way;
                  else if (p <= int'(pos)) new_row[p] = cur_row[p-1];
               end
            end
         end
         lrut_pkg::ACT_INVALIDATE: begin
            if (b_item_ff.way_ok && pos_found) begin
               for (int p = 0; p < lrut_pkg::WAYS; p++) begin
                  if (p == lrut_pkg::WAYS - 1) new_row[p] = b_item_ff.way;
                  else if (p >= int'(pos)) new_row[p] = cur_row[p+1];
               end
            end
         end
         lrut_pkg::ACT_QUERY: begin
            victim = tail_way32[lrut_pkg::VICTIM_W-1:0];
         end
         default: begin
            new_row = cur_row;
         end
      endcase
      if (b_item_ff.action != lrut_pkg::ACT_QUERY) found = 1'b0;

      rsp_tvalid_in = b_go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff      <= 1'b0;
         row_vld_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         b_vld_ff      <= b_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (b_go) row_vld_ff[b_item_ff.set] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_item_ff   <= q_item;
         b_fwd_ff    <= fwd;
         b_rowvld_ff <= row_vld_ff[q_item.set] || fwd;
      end
      if (b_go) begin
         wb_row_ff    <= new_row;
         rsp_way_ff   <= victim;
         rsp_found_ff <= found;
      end
   end

   assign rsp_tvalid       = rsp_tvalid_ff;
   assign rsp_victim_way   = rsp_way_ff;
   assign rsp_victim_found = rsp_found_ff;

endmodule

[rtl/core/lrut_checker.sv]
// ----------------------------------------------------------------------------
// lrut_checker
// Port-level checks on the recency tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lrut_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [lrut_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic [0:0]                          rsp_tuser
);

   // words accepted but not yet delivered
   logic [7:0] pend_ff, pend_in;
   logic       in_acc, out_acc;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (in_acc && !out_acc) pend_in = pend_ff + 8'd1;
      else if (out_acc && !in_acc) pend_in = pend_ff - 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 8'd0)
      else $error("response word without a pending request");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("victim way nonzero without found flag");

   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> pend_ff >= 8'(lrut_pkg::Q_DEPTH))
      else $error("request stalled with queue not full");

endmodule

bind lru_set_recency_tracker_core lrut_checker u_lrut_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
